FILE: hdl/qbcc_pkg.sv
// Package for the quasigroup byte chain cipher.
// Holds the table sizes, the control word types and the microprogram ROM.
// No dependencies.
package qbcc_pkg;

    localparam int BYTE_W     = 8;
    localparam int NUM_BYTES  = 8;
    localparam int BLOCK_W    = BYTE_W * NUM_BYTES;
    localparam int TABLE_DEPTH = 1 << (2 * BYTE_W);
    localparam int TABLE_AW   = 2 * BYTE_W;
    localparam int PC_W       = 5;
    localparam int IDX_W      = 3;

    localparam logic [1:0] ACT_LOAD_FWD = 2'd0;
    localparam logic [1:0] ACT_LOAD_INV = 2'd1;
    localparam logic [1:0] ACT_ENCRYPT  = 2'd2;
    localparam logic [1:0] ACT_DECRYPT  = 2'd3;

    localparam logic [1:0] UK_LOOK  = 2'd0;
    localparam logic [1:0] UK_LOOKJ = 2'd1;
    localparam logic [1:0] UK_FIN   = 2'd2;

    localparam logic [PC_W-1:0] PC_ENC = 5'd0;
    localparam logic [PC_W-1:0] PC_FIN = 5'd15;
    localparam logic [PC_W-1:0] PC_DEC = 5'd16;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [PC_W-1:0]  tgt;
    } t_uword;

    typedef struct packed {
        logic             busy;
        logic             look;
        logic             fin;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_ctrl;

    function automatic t_uword mk(logic [1:0] kind, logic [IDX_W-1:0] row,
                                  logic [IDX_W-1:0] col);
        t_uword w;
        w.kind = kind;
        w.row  = row;
        w.col  = col;
        w.tgt  = PC_FIN;
        return w;
    endfunction

    // Each lookup replaces the column byte with table[row byte][column byte].
    function automatic t_uword urom(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:    w = mk(UK_LOOK, 3'd0, 3'd1);
            5'd1:    w = mk(UK_LOOK, 3'd1, 3'd2);
            5'd2:    w = mk(UK_LOOK, 3'd2, 3'd3);
            5'd3:    w = mk(UK_LOOK, 3'd3, 3'd4);
            5'd4:    w = mk(UK_LOOK, 3'd4, 3'd5);
            5'd5:    w = mk(UK_LOOK, 3'd5, 3'd6);
            5'd6:    w = mk(UK_LOOK, 3'd6, 3'd7);
            5'd7:    w = mk(UK_LOOK, 3'd7, 3'd0);
            5'd8:    w = mk(UK_LOOK, 3'd6, 3'd7);
            5'd9:    w = mk(UK_LOOK, 3'd5, 3'd6);
            5'd10:   w = mk(UK_LOOK, 3'd4, 3'd5);
            5'd11:   w = mk(UK_LOOK, 3'd3, 3'd4);
            5'd12:   w = mk(UK_LOOK, 3'd2, 3'd3);
            5'd13:   w = mk(UK_LOOK, 3'd1, 3'd2);
            5'd14:   w = mk(UK_LOOK, 3'd2, 3'd1);
            5'd15:   w = mk(UK_FIN,  3'd0, 3'd0);
            5'd16:   w = mk(UK_LOOK, 3'd2, 3'd1);
            5'd17:   w = mk(UK_LOOK, 3'd1, 3'd2);
            5'd18:   w = mk(UK_LOOK, 3'd2, 3'd3);
            5'd19:   w = mk(UK_LOOK, 3'd3, 3'd4);
            5'd20:   w = mk(UK_LOOK, 3'd4, 3'd5);
            5'd21:   w = mk(UK_LOOK, 3'd5, 3'd6);
            5'd22:   w = mk(UK_LOOK, 3'd6, 3'd7);
            5'd23:   w = mk(UK_LOOK, 3'd0, 3'd7);
            5'd24:   w = mk(UK_LOOK, 3'd6, 3'd7);
            5'd25:   w = mk(UK_LOOK, 3'd5, 3'd6);
            5'd26:   w = mk(UK_LOOK, 3'd4, 3'd5);
            5'd27:   w = mk(UK_LOOK, 3'd3, 3'd4);
            5'd28:   w = mk(UK_LOOK, 3'd2, 3'd3);
            5'd29:   w = mk(UK_LOOK, 3'd1, 3'd2);
            5'd30:   w = mk(UK_LOOKJ, 3'd0, 3'd1);
            default: w = mk(UK_FIN,  3'd0, 3'd0);
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/qbcc_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module qbcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/qbcc_useq.sv
// Microprogram sequencer: program counter, ROM fetch and step control.
// Depends on qbcc_pkg.
module qbcc_useq
    import qbcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_start_dec,
    input  logic  i_hold,
    output t_ctrl o_ctrl
);

    logic            r_busy;
    logic            n_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;

    assign uw = urom(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = i_start_dec ? PC_DEC : PC_ENC;
            end
        end else begin
            case (uw.kind)
                UK_LOOK:  n_pc = r_pc + 1'b1;
                UK_LOOKJ: n_pc = uw.tgt;
                UK_FIN: begin
                    if (!i_hold) begin
                        n_busy = 1'b0;
                    end
                end
                default:  n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_ENC;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_comb begin
        o_ctrl.busy = r_busy;
        o_ctrl.look = r_busy && (uw.kind == UK_LOOK || uw.kind == UK_LOOKJ);
        o_ctrl.fin  = r_busy && (uw.kind == UK_FIN);
        o_ctrl.row  = uw.row;
        o_ctrl.col  = uw.col;
    end

endmodule

FILE: hdl/quasigroup_byte_chain_cipher.sv
// Top level: byte register file with read-data forwarding, the two tables,
// the output register and the sequencer. Depends on qbcc_pkg, qbcc_ram and qbcc_useq.
// A cipher word is accepted, then runs fifteen dependent reads of one synchronous RAM port
// and a finish step, which waits while the output is held; the next word is taken only after
// the finish step. Loads are accepted whenever the sequencer is idle.
// Reset clears the sequencer and the output valid flag; table contents stay undefined.
module quasigroup_byte_chain_cipher
    import qbcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // row_index, column_index, entry_value, block_in
    input  logic [87:0]        s_axis_tdata,
    // action
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // block_out
    output logic [BLOCK_W-1:0] m_axis_tdata
);

    t_ctrl                ctl;
    logic                 accept;
    logic                 start;
    logic                 hold;
    logic [1:0]           action;
    logic [TABLE_AW-1:0]  load_addr;
    logic [BYTE_W-1:0]    entry_value;
    logic [BLOCK_W-1:0]   block_in;

    logic [BYTE_W-1:0]    r_b [NUM_BYTES];
    logic [BYTE_W-1:0]    n_b [NUM_BYTES];
    logic [BYTE_W-1:0]    fwd [NUM_BYTES];
    logic                 r_pend;
    logic                 n_pend;
    logic [IDX_W-1:0]     r_pend_idx;
    logic                 r_tsel;
    logic                 r_out_valid;
    logic [BLOCK_W-1:0]   r_out_data;
    logic [BLOCK_W-1:0]   fwd_flat;

    logic                 fwd_we;
    logic                 inv_we;
    logic [TABLE_AW-1:0]  ram_addr;
    logic [BYTE_W-1:0]    fwd_rdata;
    logic [BYTE_W-1:0]    inv_rdata;
    logic [BYTE_W-1:0]    rdata;

    assign action      = s_axis_tuser;
    assign load_addr   = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
    assign entry_value = s_axis_tdata[23:16];
    assign block_in    = s_axis_tdata[87:24];

    assign s_axis_tready = !ctl.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (action == ACT_ENCRYPT || action == ACT_DECRYPT);
    assign hold          = r_out_valid && !m_axis_tready;

    qbcc_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_start_dec (action == ACT_DECRYPT),
        .i_hold      (hold),
        .o_ctrl      (ctl)
    );

    assign rdata = r_tsel ? inv_rdata : fwd_rdata;

    always_comb begin
        for (int i = 0; i < NUM_BYTES; i++) begin
            fwd[i] = (r_pend && r_pend_idx == IDX_W'(i)) ? rdata : r_b[i];
            fwd_flat[BYTE_W*i +: BYTE_W] = fwd[i];
        end
    end

    assign fwd_we   = accept && action == ACT_LOAD_FWD;
    assign inv_we   = accept && action == ACT_LOAD_INV;
    assign ram_addr = ctl.look ? {fwd[ctl.row], fwd[ctl.col]} : load_addr;

    qbcc_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_fwd_table (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_re    (ctl.look && !r_tsel),
        .i_addr  (ram_addr),
        .i_wdata (entry_value),
        .o_rdata (fwd_rdata)
    );

    qbcc_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_inv_table (
        .i_clk   (i_clk),
        .i_we    (inv_we),
        .i_re    (ctl.look && r_tsel),
        .i_addr  (ram_addr),
        .i_wdata (entry_value),
        .o_rdata (inv_rdata)
    );

    always_comb begin
        for (int i = 0; i < NUM_BYTES; i++) begin
            n_b[i] = start ? block_in[BYTE_W*i +: BYTE_W] : fwd[i];
        end
        n_pend = ctl.look;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (ctl.fin && !hold) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_BYTES; i++) begin
            r_b[i] <= n_b[i];
        end
        if (ctl.look) begin
            r_pend_idx <= ctl.col;
        end
        if (start) begin
            r_tsel <= action[0];
        end
        if (ctl.fin && !hold) begin
            r_out_data <= fwd_flat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_start_looks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ctl.look) else $error("cipher word did not start a lookup");
    a_look_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.look |=> r_pend) else $error("lookup result not marked pending");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.fin && !hold |=> r_out_valid && !ctl.busy)
        else $error("finish step did not present a word");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fwd_we || inv_we) |-> !ctl.busy) else $error("table write while busy");
`endif

endmodule
